/* sv/mfr_pkg.sv */
// Shared types, codes and constants of the meter frame receiver.
package mfr_pkg;

  // Input modes.
  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_POLL = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX       = 2'd0;
  localparam logic [1:0] KIND_VOLTAGE  = 2'd1;
  localparam logic [1:0] KIND_CSUM_ERR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_REQ_CODE = 2'd1;
  localparam logic [1:0] CFG_TARGET_ADDR = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [7:0]  REQ_CODE_RST = 8'd176;
  localparam logic [31:0] TARGET_ADDR_RST = {8'd192, 8'd168, 8'd1, 8'd1};

  // Frame layout.
  localparam logic [7:0] TYPE_VOLTAGE = 8'hA0;
  localparam logic [7:0] TYPE_ADDR_ACK = 8'hA4;
  localparam logic [2:0] FRAME_DATA_LEN = 3'd6;  // bytes before the checksum
  localparam logic [2:0] FRAME_KEEP_LEN = 3'd4;  // bytes stored for decoding
  localparam logic [2:0] REQ_LAST_IDX = 3'd6;    // checksum beat of a request

  // Command queue between front and back.
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW = $clog2(CMDQ_DEPTH);

  typedef enum logic [1:0] {
    CMD_REQUEST,
    CMD_VOLTAGE,
    CMD_CSUM_ERR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e     op;
    logic [19:0] voltage_tenths;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx_byte;
    logic [19:0] voltage_tenths;
    logic        last;
  } result_t;

endpackage

/* sv/mfr_front.sv */
// Front end: frame gathering, checksum check, idle timeout and command issue.
module mfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  mfr_pkg::item_t  item_i,
  input  logic [15:0]     timeout_i,
  output logic            cmd_push_o,
  output mfr_pkg::cmd_t   cmd_o
);
  import mfr_pkg::*;

  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] idle_q, idle_d;
  logic [7:0]  frame_q [FRAME_KEEP_LEN];
  logic        frame_wr;
  logic [15:0] whole;
  logic [19:0] volts;

  // The voltage is the big-endian word times ten plus the tenths byte.
  assign whole = {frame_q[1], frame_q[2]};
  assign volts = {1'b0, whole, 3'b000} + {3'b000, whole, 1'b0} + {12'd0, frame_q[3]};

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    idle_d = idle_q;
    frame_wr = 1'b0;
    cmd_push_o = 1'b0;
    cmd_o.op = CMD_CSUM_ERR;
    cmd_o.voltage_tenths = volts;
    if (accept_i) begin
      unique case (item_i.mode)
        MODE_BYTE: begin
          if (cnt_q < FRAME_DATA_LEN) begin
            frame_wr = (cnt_q < FRAME_KEEP_LEN);
            sum_d = sum_q + item_i.rx_byte;
            cnt_d = cnt_q + 3'd1;
          end else begin
            cnt_d = '0;
            sum_d = '0;
            if (sum_q != item_i.rx_byte) begin
              cmd_push_o = 1'b1;
              cmd_o.op = CMD_CSUM_ERR;
            end else begin
              idle_d = '0;
              if (frame_q[0] == TYPE_ADDR_ACK) begin
                cmd_push_o = 1'b1;
                cmd_o.op = CMD_REQUEST;
              end else if (frame_q[0] == TYPE_VOLTAGE) begin
                cmd_push_o = 1'b1;
                cmd_o.op = CMD_VOLTAGE;
              end
            end
          end
        end
        MODE_TICK: begin
          if (idle_q >= timeout_i) begin
            cnt_d = '0;
            sum_d = '0;
            idle_d = '0;
          end else begin
            idle_d = idle_q + 16'd1;
          end
        end
        MODE_POLL: begin
          cmd_push_o = 1'b1;
          cmd_o.op = CMD_REQUEST;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      idle_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_wr) begin
      frame_q[cnt_q[1:0]] <= item_i.rx_byte;
    end
  end

endmodule

/* sv/mfr_cmd_fifo.sv */
// Short command queue that decouples the front end from the result sequencer.
module mfr_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mfr_pkg::cmd_t  cmd_i,
  output logic           full_o,
  output logic           empty_o,
  input  logic           pop_i,
  output mfr_pkg::cmd_t  cmd_o
);
  import mfr_pkg::*;

  cmd_t               mem_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* sv/mfr_back.sv */
// Back end: expands commands into result beats held in an output register.
module mfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  mfr_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic [7:0]       req_code_i,
  input  logic [31:0]      target_addr_i,
  output logic             res_valid_o,
  input  logic             res_pop_i,
  output mfr_pkg::result_t res_o
);
  import mfr_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic [7:0] sum_q, sum_d;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       advance;
  logic [7:0] req_byte;

  // A new beat may be produced whenever the output register is free or drains.
  assign advance = cmd_valid_i && (!out_valid_q || res_pop_i);

  always_comb begin
    unique case (idx_q)
      3'd0:    req_byte = req_code_i;
      3'd1:    req_byte = target_addr_i[31:24];
      3'd2:    req_byte = target_addr_i[23:16];
      3'd3:    req_byte = target_addr_i[15:8];
      3'd4:    req_byte = target_addr_i[7:0];
      3'd6:    req_byte = sum_q;
      default: req_byte = '0;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    cmd_pop_o = 1'b0;
    out_valid_d = out_valid_q && !res_pop_i;
    out_d = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d.tx_byte = '0;
      out_d.voltage_tenths = '0;
      out_d.last = 1'b1;
      unique case (cmd_i.op)
        CMD_REQUEST: begin
          out_d.kind = KIND_TX;
          out_d.tx_byte = req_byte;
          if (idx_q == REQ_LAST_IDX) begin
            cmd_pop_o = 1'b1;
            idx_d = '0;
            sum_d = '0;
          end else begin
            out_d.last = 1'b0;
            idx_d = idx_q + 3'd1;
            sum_d = sum_q + req_byte;
          end
        end
        CMD_VOLTAGE: begin
          out_d.kind = KIND_VOLTAGE;
          out_d.voltage_tenths = cmd_i.voltage_tenths;
          cmd_pop_o = 1'b1;
        end
        default: begin
          out_d.kind = KIND_CSUM_ERR;
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

endmodule

/* sv/meter_frame_receiver_core.sv */
// Top level of the meter frame receiver: configuration registers and block wiring.
//
// Input side is a queue port: an item (mode and rx_byte) is taken on each clock
// edge where push is high and full is low. Received bytes are gathered into
// seven-byte frames, millisecond ticks advance the idle timer, and poll requests
// ask for a request frame to be sent. One item is taken per cycle while not full.
// Result side is also a queue port: while empty is low the oldest result beat is
// on result_o, and it leaves on a clock edge with pop high.
// A checksum error or a voltage reading gives one beat; a request frame gives
// seven beats, one per cycle while pop is high, the last one flagged.
// A single-beat result passes through the command queue and then the output
// register before it shows on the result ports.
// The front end issues commands into a four-entry queue; the back end drains one
// beat per cycle while pop is high, so full rises only when requests pile up
// faster than their beats can leave the output, or when the receiver stops popping.
// A stalled receiver holds its beat; the queue keeps absorbing items until full.
// The configuration port writes timeout_ticks, request_code or target_address
// on cfg_valid_i, is always ready, and is meant to be used while the block is idle.
// Reset empties the queue and output register, clears the frame count, checksum
// and idle timer, and loads the documented register defaults.
module meter_frame_receiver_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  mfr_pkg::item_t   item_i,
  output logic             empty,
  input  logic             pop,
  output mfr_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [31:0]      cfg_data_i
);
  import mfr_pkg::*;

  logic [15:0] timeout_q;
  logic [7:0]  req_code_q;
  logic [31:0] target_addr_q;

  logic accept;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop, res_valid;
  cmd_t cmd_in, cmd_head;

  // Register writes always complete in the cycle they are offered.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      req_code_q <= REQ_CODE_RST;
      target_addr_q <= TARGET_ADDR_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIMEOUT:     timeout_q <= cfg_data_i[15:0];
        CFG_REQ_CODE:    req_code_q <= cfg_data_i[7:0];
        CFG_TARGET_ADDR: target_addr_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The input stalls only when the command queue has no room left.
  assign full = cmd_full;
  assign accept = push && !cmd_full;

  mfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item_i),
    .timeout_i  (timeout_q),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  mfr_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .empty_o (cmd_empty),
    .pop_i   (cmd_pop),
    .cmd_o   (cmd_head)
  );

  mfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .req_code_i    (req_code_q),
    .target_addr_i (target_addr_q),
    .res_valid_o   (res_valid),
    .res_pop_i     (pop),
    .res_o         (result_o)
  );

  assign empty = !res_valid;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of meter_frame_receiver_core: directed tests, then random traffic.
module testbench;
  import mfr_pkg::*;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS = 30;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  item_t       item;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // Mirror of the block's registers and frame state.
  logic [15:0] timeout_q;
  logic [7:0]  req_code_q;
  logic [31:0] target_addr_q;
  logic [7:0]  frame_q [6];
  logic [2:0]  byte_cnt_q;
  logic [7:0]  sum_q;
  logic [15:0] idle_q;

  result_t     expected_beats [$];
  result_t     want_beat;
  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  meter_frame_receiver_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .push        (push),
    .full        (full),
    .item_i      (item),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t mk_item(input logic [1:0] mode, input logic [7:0] rx);
    item_t it;
    it.mode = mode;
    it.rx_byte = rx;
    return it;
  endfunction

  function automatic void queue_beat(input logic [1:0] kind, input logic [7:0] tx,
                                     input logic [19:0] volts, input logic last);
    result_t r;
    r.kind = kind;
    r.tx_byte = tx;
    r.voltage_tenths = volts;
    r.last = last;
    expected_beats.push_back(r);
  endfunction

  function automatic void queue_request_frame();
    logic [7:0] b [7];
    b[0] = req_code_q;
    b[1] = target_addr_q[31:24];
    b[2] = target_addr_q[23:16];
    b[3] = target_addr_q[15:8];
    b[4] = target_addr_q[7:0];
    b[5] = 8'h00;
    b[6] = b[0] + b[1] + b[2] + b[3] + b[4] + b[5];
    for (int i = 0; i < 7; i++) queue_beat(KIND_TX, b[i], 20'd0, i == 6);
  endfunction

  function automatic void reset_frame_state();
    timeout_q = TIMEOUT_RST;
    req_code_q = REQ_CODE_RST;
    target_addr_q = TARGET_ADDR_RST;
    for (int i = 0; i < 6; i++) frame_q[i] = 8'h00;
    byte_cnt_q = '0;
    sum_q = '0;
    idle_q = '0;
  endfunction

  // Updates the mirrored state for one accepted item and queues its result beats.
  function automatic void predict_meter_item(input item_t it);
    logic [19:0] volts;
    case (it.mode)
      MODE_BYTE: begin
        if (byte_cnt_q < FRAME_DATA_LEN) begin
          frame_q[byte_cnt_q] = it.rx_byte;
          sum_q = sum_q + it.rx_byte;
          byte_cnt_q = byte_cnt_q + 3'd1;
        end else begin
          byte_cnt_q = '0;
          if (sum_q != it.rx_byte) begin
            queue_beat(KIND_CSUM_ERR, 8'h00, 20'd0, 1'b1);
          end else begin
            idle_q = '0;
            if (frame_q[0] == TYPE_ADDR_ACK) begin
              queue_request_frame();
            end else if (frame_q[0] == TYPE_VOLTAGE) begin
              volts = {4'd0, frame_q[1], frame_q[2]} * 20'd10 + {12'd0, frame_q[3]};
              queue_beat(KIND_VOLTAGE, 8'h00, volts, 1'b1);
            end
          end
          sum_q = '0;
        end
      end
      MODE_TICK: begin
        if (idle_q >= timeout_q) begin
          byte_cnt_q = '0;
          sum_q = '0;
          idle_q = '0;
        end else begin
          idle_q = idle_q + 16'd1;
        end
      end
      MODE_POLL: queue_request_frame();
      default: ;
    endcase
  endfunction

  // Sends one item from a falling edge and returns at the falling edge after it is taken.
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push = 1'b1;
    item = it;
    do @(posedge clk); while (full);
    predict_meter_item(it);
    @(negedge clk);
  endtask

  // Sends six frame bytes (byte 0 in the top bits) and a checksum, optionally corrupted.
  task automatic send_frame(input logic [47:0] body, input bit corrupt,
                            input int unsigned tick_pct);
    logic [7:0] csum;
    csum = '0;
    for (int i = 5; i >= 0; i--) begin
      if ($urandom_range(99) < tick_pct) send_item(mk_item(MODE_TICK, 8'($urandom)));
      send_item(mk_item(MODE_BYTE, body[i*8 +: 8]));
      csum = csum + body[i*8 +: 8];
    end
    if (corrupt) csum = csum + 8'($urandom_range(1, 255));
    send_item(mk_item(MODE_BYTE, csum));
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TIMEOUT:     timeout_q = data[15:0];
      CFG_REQ_CODE:    req_code_q = data[7:0];
      CFG_TARGET_ADDR: target_addr_q = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Waits until every expected beat has left, then lets the pipeline settle.
  task automatic wait_idle();
    push = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
  endtask

  task automatic test_poll_defaults();
    send_item(mk_item(MODE_POLL, 8'hFF));
  endtask

  task automatic test_unused_mode();
    send_item(mk_item(MODE_UNUSED, 8'h5A));
  endtask

  task automatic test_voltage_extreme();
    send_frame({TYPE_VOLTAGE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00}, 1'b0, 0);
  endtask

  task automatic test_addr_ack();
    send_frame({TYPE_ADDR_ACK, $urandom, 8'($urandom)}, 1'b0, 0);
  endtask

  task automatic test_bad_checksum();
    send_frame({TYPE_VOLTAGE, $urandom, 8'($urandom)}, 1'b1, 0);
  endtask

  task automatic test_config(input logic [15:0] tmo, input logic [7:0] code,
                             input logic [31:0] addr);
    wait_idle();
    write_cfg(CFG_TIMEOUT, {16'd0, tmo});
    write_cfg(CFG_REQ_CODE, {24'd0, code});
    write_cfg(CFG_TARGET_ADDR, addr);
  endtask

  // Mostly aligned frames with random bodies, mixed with ticks, polls and noise.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [7:0]  type_byte;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        // Finish any partial frame with noise so the next frame is aligned.
        while (byte_cnt_q != 0) begin
          send_item(mk_item(MODE_BYTE, 8'($urandom)));
          sent++;
        end
        case ($urandom_range(2))
          0: type_byte = TYPE_VOLTAGE;
          1: type_byte = TYPE_ADDR_ACK;
          default: type_byte = 8'($urandom);
        endcase
        send_frame({type_byte, $urandom, 8'($urandom)}, $urandom_range(9) == 0, 8);
        sent += 7;
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 8)) begin
          send_item(mk_item(MODE_TICK, 8'($urandom)));
          sent++;
        end
      end else if (pick < 86) begin
        send_item(mk_item(MODE_POLL, 8'($urandom)));
        sent++;
      end else if (pick < 96) begin
        send_item(mk_item(MODE_BYTE, 8'($urandom)));
        sent++;
      end else begin
        send_item(mk_item(MODE_UNUSED, 8'($urandom)));
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Each popped beat is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: kind %0d tx_byte %0d", result.kind, result.tx_byte);
        error_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (result.kind !== want_beat.kind) begin
          $error("kind: expected %0d, actual %0d", want_beat.kind, result.kind);
          error_count++;
        end
        if (result.tx_byte !== want_beat.tx_byte) begin
          $error("tx_byte: expected %0d, actual %0d", want_beat.tx_byte, result.tx_byte);
          error_count++;
        end
        if (result.voltage_tenths !== want_beat.voltage_tenths) begin
          $error("voltage_tenths: expected %0d, actual %0d",
                 want_beat.voltage_tenths, result.voltage_tenths);
          error_count++;
        end
        if (result.last !== want_beat.last) begin
          $error("last: expected %0d, actual %0d", want_beat.last, result.last);
          error_count++;
        end
      end
    end
  end

  // Ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reset_frame_state();
    set_idling(0, 0);
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_poll_defaults();
    test_unused_mode();
    test_voltage_extreme();
    test_addr_ack();
    test_bad_checksum();

    test_config(16'd1, 8'h00, 32'h0000_0000);
    test_random_traffic(PHASE_ITEMS);

    test_config(16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    set_idling(70, 0);
    test_random_traffic(PHASE_ITEMS);

    test_config(16'd0, 8'($urandom), $urandom);
    set_idling(0, 70);
    test_random_traffic(PHASE_ITEMS);

    test_config(16'($urandom_range(2, 20)), 8'($urandom), $urandom);
    set_idling(13, 13);
    test_random_traffic(PHASE_ITEMS);

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mfr_pkg.sv
sv/mfr_front.sv
sv/mfr_cmd_fifo.sv
sv/mfr_back.sv
sv/meter_frame_receiver_core.sv
tb/sv/testbench.sv
